// ----- rtl/rpsd_pkg.sv -----
// shared constants, widths and types for the ray to plane distance pipeline
`timescale 1ns / 1ps
package rpsd_pkg;

  localparam int THR_W      = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd3277;

  localparam int MUL_LAT    = 3;
  localparam int FRONT_LAT  = 4;
  localparam int ROOT_STEPS = 32;
  localparam int LATENCY    = FRONT_LAT + 3 * MUL_LAT + 1 + ROOT_STEPS + 1;

  localparam int WAP   = 65;
  localparam int WAR   = 64;
  localparam int WQ    = 64;
  localparam int WNN   = 64;
  localparam int WBASE = 65;
  localparam int WNK2  = 63;
  localparam int WP2   = 2 * WAP;
  localparam int WR2   = 2 * WAR;
  localparam int WX    = WBASE + WAR;
  localparam int WY    = THR_W + WNK2;
  localparam int WN    = WP2 + WQ;
  localparam int WX2   = 2 * WX;
  localparam int WY2   = 2 * WY;
  localparam int WZ    = WY2 + WNN;

  localparam logic [31:0] DIST_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] DIST_NEG_MAG = 32'h8000_0000;

  typedef struct packed {
    logic deg;
    logic zero_r;
    logic par;
    logic neg;
  } rpsd_flags_t;

  localparam int WF = $bits(rpsd_flags_t);

endpackage

// ----- rtl/ray_plane_signed_distance.sv -----
// top level of the ray to plane signed distance pipeline
`timescale 1ns / 1ps
// usage
//   a request (ray origin, ray direction, plane point, plane normal, all signed
//   q16.16) is taken at every clock edge with start high; busy stays low, so a
//   new request may follow in every cycle
//   each request gives exactly one result: out_strobe is high for one cycle with
//   out_signed_distance, out_parallel_flag and out_degenerate_flag
//   throughput one request per cycle; each result passes through the four front
//   stages, three chained 3-stage multipliers, the compare stage, the 32-stage
//   bit-serial root and the output register
//   the receiver cannot stall; results are never held back
//   cfg_we writes cfg_wdata into the parallel threshold; write only while idle
//   synchronous reset (rst_n low) clears all valid bits and loads the default
//   threshold; requests in flight are dropped
module ray_plane_signed_distance (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           in_ray_point_x,
  input  logic signed [31:0]           in_ray_point_y,
  input  logic signed [31:0]           in_ray_point_z,
  input  logic signed [31:0]           in_ray_dir_x,
  input  logic signed [31:0]           in_ray_dir_y,
  input  logic signed [31:0]           in_ray_dir_z,
  input  logic signed [31:0]           in_plane_point_x,
  input  logic signed [31:0]           in_plane_point_y,
  input  logic signed [31:0]           in_plane_point_z,
  input  logic signed [31:0]           in_plane_normal_x,
  input  logic signed [31:0]           in_plane_normal_y,
  input  logic signed [31:0]           in_plane_normal_z,
  input  logic                         cfg_we,
  input  logic [rpsd_pkg::THR_W-1:0]   cfg_wdata,
  output logic                         out_strobe,
  output logic signed [31:0]           out_signed_distance,
  output logic                         out_parallel_flag,
  output logic                         out_degenerate_flag
);
  import rpsd_pkg::*;

  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  logic signed [31:0] rp [3];
  logic signed [31:0] dv [3];
  logic signed [31:0] pp [3];
  logic signed [31:0] nv [3];

  assign rp = '{in_ray_point_x, in_ray_point_y, in_ray_point_z};
  assign dv = '{in_ray_dir_x, in_ray_dir_y, in_ray_dir_z};
  assign pp = '{in_plane_point_x, in_plane_point_y, in_plane_point_z};
  assign nv = '{in_plane_normal_x, in_plane_normal_y, in_plane_normal_z};

  logic             fr_valid;
  rpsd_flags_t      fr_flags;
  logic [WAP-1:0]   fr_ap;
  logic [WAR-1:0]   fr_ar;
  logic [WQ-1:0]    fr_q;
  logic [WNN-1:0]   fr_nn;
  logic [WBASE-1:0] fr_base;
  logic [WNK2-1:0]  fr_nk2;

  rpsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .rp_in     (rp),
    .dv_in     (dv),
    .pp_in     (pp),
    .nv_in     (nv),
    .out_valid (fr_valid),
    .out_flags (fr_flags),
    .out_ap    (fr_ap),
    .out_ar    (fr_ar),
    .out_q     (fr_q),
    .out_nn    (fr_nn),
    .out_base  (fr_base),
    .out_nk2   (fr_nk2)
  );

  // first multiplier level
  logic [WP2-1:0] p2;
  logic [WR2-1:0] r2;
  logic [WX-1:0]  x1;
  logic [WY-1:0]  y1;

  rpsd_mul #(.WA(WAP),   .WB(WAP))  u_mul_p2 (.clk(clk), .a(fr_ap),   .b(fr_ap),  .p(p2));
  rpsd_mul #(.WA(WAR),   .WB(WAR))  u_mul_r2 (.clk(clk), .a(fr_ar),   .b(fr_ar),  .p(r2));
  rpsd_mul #(.WA(WBASE), .WB(WAR))  u_mul_x  (.clk(clk), .a(fr_base), .b(fr_ar),  .p(x1));
  rpsd_mul #(.WA(THR_W), .WB(WNK2)) u_mul_y  (.clk(clk), .a(thr_r),   .b(fr_nk2), .p(y1));

  logic             d1_valid;
  logic [WQ-1:0]    d1_q;
  logic [WNN-1:0]   d1_nn;
  rpsd_flags_t      d1_flags;

  rpsd_delay #(.W(WQ + WNN + WF), .DEPTH(MUL_LAT)) u_dly1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_data   ({fr_q, fr_nn, fr_flags}),
    .out_valid (d1_valid),
    .out_data  ({d1_q, d1_nn, d1_flags})
  );

  // second multiplier level
  logic [WN-1:0]  num;
  logic [WX2-1:0] x2;
  logic [WY2-1:0] y2;

  rpsd_mul #(.WA(WP2), .WB(WQ)) u_mul_n  (.clk(clk), .a(p2), .b(d1_q), .p(num));
  rpsd_mul #(.WA(WX),  .WB(WX)) u_mul_x2 (.clk(clk), .a(x1), .b(x1),   .p(x2));
  rpsd_mul #(.WA(WY),  .WB(WY)) u_mul_y2 (.clk(clk), .a(y1), .b(y1),   .p(y2));

  logic             d2_valid;
  logic [WNN-1:0]   d2_nn;
  logic [WR2-1:0]   d2_r2;
  rpsd_flags_t      d2_flags;

  rpsd_delay #(.W(WNN + WR2 + WF), .DEPTH(MUL_LAT)) u_dly2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_valid),
    .in_data   ({d1_nn, r2, d1_flags}),
    .out_valid (d2_valid),
    .out_data  ({d2_nn, d2_r2, d2_flags})
  );

  // third multiplier level
  logic [WZ-1:0] z;

  rpsd_mul #(.WA(WY2), .WB(WNN)) u_mul_z (.clk(clk), .a(y2), .b(d2_nn), .p(z));

  logic             d3_valid;
  logic [WN-1:0]    d3_num;
  logic [WR2-1:0]   d3_r2;
  logic [WX2-1:0]   d3_x2;
  rpsd_flags_t      d3_flags;

  rpsd_delay #(.W(WN + WR2 + WX2 + WF), .DEPTH(MUL_LAT)) u_dly3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d2_valid),
    .in_data   ({num, d2_r2, x2, d2_flags}),
    .out_valid (d3_valid),
    .out_data  ({d3_num, d3_r2, d3_x2, d3_flags})
  );

  // parallel test
  logic           cmp_valid_r;
  rpsd_flags_t    cmp_flags_nxt, cmp_flags_r;
  logic [WN-1:0]  cmp_num_r;
  logic [WR2-1:0] cmp_den_r;

  always_comb begin
    cmp_flags_nxt     = d3_flags;
    cmp_flags_nxt.par = d3_flags.zero_r || (d3_x2 < WX2'(z));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
    end else begin
      cmp_valid_r <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    cmp_flags_r <= cmp_flags_nxt;
    cmp_num_r   <= d3_num;
    cmp_den_r   <= d3_r2;
  end

  logic        rt_valid;
  rpsd_flags_t rt_flags;
  logic [31:0] rt_root;

  rpsd_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmp_valid_r),
    .in_flags  (cmp_flags_r),
    .in_num    (cmp_num_r),
    .in_den    (cmp_den_r),
    .out_valid (rt_valid),
    .out_flags (rt_flags),
    .out_root  (rt_root)
  );

  // result register
  logic        strobe_r;
  logic [31:0] dist_nxt, dist_r;
  logic        par_r, deg_r;

  always_comb begin
    if (rt_flags.deg) begin
      dist_nxt = '0;
    end else if (rt_flags.par) begin
      dist_nxt = DIST_MAX;
    end else if (rt_flags.neg) begin
      dist_nxt = 32'(-rt_root);
    end else begin
      dist_nxt = rt_root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    par_r  <= !rt_flags.deg && rt_flags.par;
    deg_r  <= rt_flags.deg;
  end

  assign out_strobe          = strobe_r;
  assign out_signed_distance = signed'(dist_r);
  assign out_parallel_flag   = par_r;
  assign out_degenerate_flag = deg_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("request without result at the expected cycle");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_parallel_flag && out_degenerate_flag))
    else $error("parallel and degenerate both set");

  a_par_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_parallel_flag) |-> (out_signed_distance == signed'(DIST_MAX)))
    else $error("parallel result not at maximum");

  a_deg_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_degenerate_flag) |-> (out_signed_distance == 32'sd0))
    else $error("degenerate result not zero");

endmodule

// ----- rtl/rpsd_mul.sv -----
// pipelined unsigned multiplier built from 32x32 partial products, three register stages
`timescale 1ns / 1ps
module rpsd_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic              clk,
  input  logic [WA-1:0]     a,
  input  logic [WB-1:0]     b,
  output logic [WA+WB-1:0]  p
);
  localparam int NA   = (WA + 31) / 32;
  localparam int NB   = (WB + 31) / 32;
  localparam int WROW = NB * 32 + 32;
  localparam int WACC = NA * 32 + NB * 32;

  logic [NA*32-1:0]   a_ext;
  logic [NB*32-1:0]   b_ext;
  logic [63:0]        pp_r [NA][NB];
  logic [WROW-1:0]    row_nxt [NA];
  logic [WROW-1:0]    row_r [NA];
  logic [WACC-1:0]    acc_nxt;
  logic [WA+WB-1:0]   p_r;

  assign a_ext = (NA*32)'(a);
  assign b_ext = (NB*32)'(b);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (WROW'(pp_r[i][j]) << (32 * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      acc_nxt = acc_nxt + (WACC'(row_r[i]) << (32 * i));
    end
  end

  always_ff @(posedge clk) begin
    p_r <= acc_nxt[WA+WB-1:0];
  end

  assign p = p_r;

endmodule

// ----- rtl/rpsd_delay.sv -----
// fixed-length delay line for side data and its valid bit
`timescale 1ns / 1ps
module rpsd_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);
  logic         vld_r [DEPTH];
  logic [W-1:0] dat_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dat_r[0] <= in_data;
    for (int i = 1; i < DEPTH; i++) dat_r[i] <= dat_r[i-1];
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = dat_r[DEPTH-1];

endmodule

// ----- rtl/rpsd_front.sv -----
// front end: differences, dot products, squared norms and the parallel test base term
`timescale 1ns / 1ps
module rpsd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic signed [31:0]        rp_in [3],
  input  logic signed [31:0]        dv_in [3],
  input  logic signed [31:0]        pp_in [3],
  input  logic signed [31:0]        nv_in [3],
  output logic                      out_valid,
  output rpsd_pkg::rpsd_flags_t     out_flags,
  output logic [rpsd_pkg::WAP-1:0]  out_ap,
  output logic [rpsd_pkg::WAR-1:0]  out_ar,
  output logic [rpsd_pkg::WQ-1:0]   out_q,
  output logic [rpsd_pkg::WNN-1:0]  out_nn,
  output logic [rpsd_pkg::WBASE-1:0] out_base,
  output logic [rpsd_pkg::WNK2-1:0] out_nk2
);
  import rpsd_pkg::*;

  // stage 1
  logic signed [32:0] b_nxt [3];
  logic signed [32:0] b_r [3];
  logic signed [31:0] dv_r [3];
  logic signed [31:0] nv_r [3];
  logic signed [31:0] nk_nxt, nk_r;
  logic signed [32:0] s_nxt, s_r;
  logic               deg_nxt, deg1_r, vld1_r;

  always_comb begin
    deg_nxt = (nv_in[0] == '0) && (nv_in[1] == '0) && (nv_in[2] == '0);
    if (nv_in[2] != '0) begin
      nk_nxt = nv_in[2];
      s_nxt  = 33'(nv_in[0]) + 33'(nv_in[1]);
    end else if (nv_in[1] != '0) begin
      nk_nxt = nv_in[1];
      s_nxt  = 33'(nv_in[2]) + 33'(nv_in[0]);
    end else begin
      nk_nxt = nv_in[0];
      s_nxt  = 33'(nv_in[1]) + 33'(nv_in[2]);
    end
    for (int i = 0; i < 3; i++) b_nxt[i] = 33'(rp_in[i]) - 33'(pp_in[i]);
  end

  always_ff @(posedge clk) begin
    b_r    <= b_nxt;
    dv_r   <= dv_in;
    nv_r   <= nv_in;
    nk_r   <= nk_nxt;
    s_r    <= s_nxt;
    deg1_r <= deg_nxt;
  end

  // stage 2: products
  logic signed [64:0] pb_nxt [3];
  logic signed [63:0] pr_nxt [3];
  logic signed [63:0] sqd [3];
  logic signed [63:0] sqn [3];
  logic signed [63:0] sqk;
  logic [32:0]        s_abs;
  logic signed [64:0] pb_r [3];
  logic signed [63:0] pr_r [3];
  logic [62:0]        pd_r [3];
  logic [62:0]        pn_r [3];
  logic [62:0]        nk2_r;
  logic [64:0]        s2_r;
  logic               deg2_r, vld2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pb_nxt[i] = b_r[i] * nv_r[i];
      pr_nxt[i] = dv_r[i] * nv_r[i];
      sqd[i]    = dv_r[i] * dv_r[i];
      sqn[i]    = nv_r[i] * nv_r[i];
    end
    sqk   = nk_r * nk_r;
    s_abs = s_r[32] ? 33'(-s_r) : 33'(s_r);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pb_r[i] <= pb_nxt[i];
      pr_r[i] <= pr_nxt[i];
      pd_r[i] <= sqd[i][62:0];
      pn_r[i] <= sqn[i][62:0];
    end
    nk2_r  <= sqk[62:0];
    s2_r   <= 65'(s_abs) * 65'(s_abs);
    deg2_r <= deg1_r;
  end

  // stage 3: sums
  logic signed [66:0] p3_r;
  logic signed [65:0] r3_r;
  logic [WQ-1:0]      q3_r;
  logic [WNN-1:0]     nn3_r;
  logic [WBASE-1:0]   base3_r;
  logic [WNK2-1:0]    nk2_3_r;
  logic               deg3_r, vld3_r;

  always_ff @(posedge clk) begin
    p3_r    <= 67'(pb_r[0]) + 67'(pb_r[1]) + 67'(pb_r[2]);
    r3_r    <= 66'(pr_r[0]) + 66'(pr_r[1]) + 66'(pr_r[2]);
    q3_r    <= WQ'(pd_r[0]) + WQ'(pd_r[1]) + WQ'(pd_r[2]);
    nn3_r   <= WNN'(pn_r[0]) + WNN'(pn_r[1]) + WNN'(pn_r[2]);
    base3_r <= WBASE'(s2_r) + WBASE'({nk2_r, 1'b0});
    nk2_3_r <= nk2_r;
    deg3_r  <= deg2_r;
  end

  // stage 4: magnitudes and signs
  logic [WAP-1:0]   ap_r;
  logic [WAR-1:0]   ar_r;
  logic [WQ-1:0]    q4_r;
  logic [WNN-1:0]   nn4_r;
  logic [WBASE-1:0] base4_r;
  logic [WNK2-1:0]  nk2_4_r;
  rpsd_flags_t      flags_nxt, flags_r;
  logic             vld4_r;

  always_comb begin
    flags_nxt.deg    = deg3_r;
    flags_nxt.zero_r = (r3_r == '0);
    flags_nxt.par    = 1'b0;
    flags_nxt.neg    = (p3_r != '0) && (p3_r[66] == r3_r[65]);
  end

  always_ff @(posedge clk) begin
    ap_r    <= p3_r[66] ? WAP'(-p3_r) : WAP'(p3_r);
    ar_r    <= r3_r[65] ? WAR'(-r3_r) : WAR'(r3_r);
    q4_r    <= q3_r;
    nn4_r   <= nn3_r;
    base4_r <= base3_r;
    nk2_4_r <= nk2_3_r;
    flags_r <= flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  assign out_valid = vld4_r;
  assign out_flags = flags_r;
  assign out_ap    = ap_r;
  assign out_ar    = ar_r;
  assign out_q     = q4_r;
  assign out_nn    = nn4_r;
  assign out_base  = base4_r;
  assign out_nk2   = nk2_4_r;

endmodule

// ----- rtl/rpsd_root.sv -----
// bit-serial search, one bit per stage: largest m <= lim with m^2 * den <= num
`timescale 1ns / 1ps
module rpsd_root (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  rpsd_pkg::rpsd_flags_t    in_flags,
  input  logic [rpsd_pkg::WN-1:0]  in_num,
  input  logic [rpsd_pkg::WR2-1:0] in_den,
  output logic                     out_valid,
  output rpsd_pkg::rpsd_flags_t    out_flags,
  output logic [31:0]              out_root
);
  import rpsd_pkg::*;

  localparam int WU = WR2 + 32;
  localparam int WT = WN + 2;

  logic            vld_in [ROOT_STEPS];
  rpsd_flags_t     flg_in [ROOT_STEPS];
  logic [WN-1:0]   rem_in [ROOT_STEPS];
  logic [WU-1:0]   u_in   [ROOT_STEPS];
  logic [WR2-1:0]  den_in [ROOT_STEPS];
  logic [31:0]     m_in   [ROOT_STEPS];

  logic            vld_r [ROOT_STEPS];
  rpsd_flags_t     flg_r [ROOT_STEPS];
  logic [WN-1:0]   rem_r [ROOT_STEPS];
  logic [WU-1:0]   u_r   [ROOT_STEPS];
  logic [WR2-1:0]  den_r [ROOT_STEPS];
  logic [31:0]     m_r   [ROOT_STEPS];

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_step
    localparam int B = ROOT_STEPS - 1 - g;
    logic [31:0]   cand;
    logic [31:0]   lim;
    logic [WT-1:0] term;
    logic          ok;

    if (g == 0) begin : g_first
      assign vld_in[g] = in_valid;
      assign flg_in[g] = in_flags;
      assign rem_in[g] = in_num;
      assign u_in[g]   = '0;
      assign den_in[g] = in_den;
      assign m_in[g]   = '0;
    end else begin : g_next
      assign vld_in[g] = vld_r[g-1];
      assign flg_in[g] = flg_r[g-1];
      assign rem_in[g] = rem_r[g-1];
      assign u_in[g]   = u_r[g-1];
      assign den_in[g] = den_r[g-1];
      assign m_in[g]   = m_r[g-1];
    end

    // (m + 2^b)^2 d - m^2 d = 2^(b+1) m d + 2^(2b) d
    assign cand = m_in[g] | (32'(1) << B);
    assign lim  = flg_in[g].neg ? DIST_NEG_MAG : DIST_MAX;
    assign term = (WT'(u_in[g]) << (B + 1)) + (WT'(den_in[g]) << (2 * B));
    assign ok   = (cand <= lim) && (term <= WT'(rem_in[g]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in[g];
      end
    end

    always_ff @(posedge clk) begin
      flg_r[g] <= flg_in[g];
      den_r[g] <= den_in[g];
      if (ok) begin
        rem_r[g] <= rem_in[g] - WN'(term);
        u_r[g]   <= u_in[g] + (WU'(den_in[g]) << B);
        m_r[g]   <= cand;
      end else begin
        rem_r[g] <= rem_in[g];
        u_r[g]   <= u_in[g];
        m_r[g]   <= m_in[g];
      end
    end
  end

  assign out_valid = vld_r[ROOT_STEPS-1];
  assign out_flags = flg_r[ROOT_STEPS-1];
  assign out_root  = m_r[ROOT_STEPS-1];

endmodule

// ----- tb/ray_plane_signed_distance_check.sv -----
// checker for the ray to plane distance block: prediction and comparison of results
`timescale 1ns / 1ps
module ray_plane_signed_distance_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_ray_point_x,
  input  logic signed [31:0] in_ray_point_y,
  input  logic signed [31:0] in_ray_point_z,
  input  logic signed [31:0] in_ray_dir_x,
  input  logic signed [31:0] in_ray_dir_y,
  input  logic signed [31:0] in_ray_dir_z,
  input  logic signed [31:0] in_plane_point_x,
  input  logic signed [31:0] in_plane_point_y,
  input  logic signed [31:0] in_plane_point_z,
  input  logic signed [31:0] in_plane_normal_x,
  input  logic signed [31:0] in_plane_normal_y,
  input  logic signed [31:0] in_plane_normal_z,
  input  logic               cfg_we,
  input  logic [rpsd_pkg::THR_W-1:0] cfg_wdata,
  input  logic               out_strobe,
  input  logic signed [31:0] out_signed_distance,
  input  logic               out_parallel_flag,
  input  logic               out_degenerate_flag,
  output int                 errors,
  output int                 pending
);
  import rpsd_pkg::*;

  typedef struct {
    logic [31:0] distance;
    logic        par;
    logic        deg;
  } hit_t;

  typedef logic [319:0] big_t;

  logic [THR_W-1:0] threshold;
  hit_t hits_due[$];

  function automatic hit_t predict_hit(input longint orig[3], input longint dir[3],
                                       input longint ppt[3], input longint nrm[3],
                                       input logic [THR_W-1:0] thr);
    hit_t h;
    int k;
    longint s;
    logic signed [71:0] p, r, ap, ar;
    big_t q, nn, nk2, sm, base, r2, lhs, rhs, pq, c, m, lim, t2;
    logic neg;
    h.distance = 32'd0;
    h.par = 1'b0;
    h.deg = 1'b0;
    if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) begin
      h.deg = 1'b1;
      return h;
    end
    k = (nrm[2] != 0) ? 2 : ((nrm[1] != 0) ? 1 : 0);
    s = nrm[(k + 1) % 3] + nrm[(k + 2) % 3];
    p = 0;
    r = 0;
    q = 0;
    nn = 0;
    for (int i = 0; i < 3; i++) begin
      p += 72'((orig[i] - ppt[i]) * nrm[i]);
      r += 72'(dir[i] * nrm[i]);
      q += 320'(dir[i] * dir[i]);
      nn += 320'(nrm[i] * nrm[i]);
    end
    if (r != 0) begin
      ar = (r < 0) ? -r : r;
      ap = (p < 0) ? -p : p;
      nk2 = 320'(nrm[k] * nrm[k]);
      sm = 320'((s < 0) ? -s : s);
      base = sm * sm + 2 * nk2;
      r2 = 320'(ar);
      r2 = r2 * r2;
      lhs = base * base * r2;
      t2 = 320'(thr);
      rhs = t2 * t2 * nn * nk2 * nk2;
      if (lhs >= rhs) begin
        neg = (p != 0) && ((p < 0) == (r < 0));
        lim = neg ? 320'h8000_0000 : 320'h7FFF_FFFF;
        pq = 320'(ap);
        pq = pq * pq * q;
        m = 0;
        for (int b = 31; b >= 0; b--) begin
          c = m | (320'd1 << b);
          if (c <= lim && c * c * r2 <= pq) m = c;
        end
        h.distance = neg ? -m[31:0] : m[31:0];
        return h;
      end
    end
    h.distance = DIST_MAX;
    h.par = 1'b1;
    return h;
  endfunction

  assign pending = hits_due.size();

  initial errors = 0;

  always @(posedge clk) begin
    hit_t want;
    longint orig[3], dir[3], ppt[3], nrm[3];
    if (!rst_n) begin
      threshold <= THR_RESET;
      hits_due.delete();
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (start && !busy) begin
        orig = '{in_ray_point_x, in_ray_point_y, in_ray_point_z};
        dir  = '{in_ray_dir_x, in_ray_dir_y, in_ray_dir_z};
        ppt  = '{in_plane_point_x, in_plane_point_y, in_plane_point_z};
        nrm  = '{in_plane_normal_x, in_plane_normal_y, in_plane_normal_z};
        hits_due.push_back(predict_hit(orig, dir, ppt, nrm, threshold));
      end
      if (out_strobe) begin
        if (hits_due.size() == 0) begin
          errors++;
          $display("%0t: result with none due: distance %h par %b deg %b", $time,
                   out_signed_distance, out_parallel_flag, out_degenerate_flag);
        end else begin
          want = hits_due.pop_front();
          if (out_signed_distance !== want.distance) begin
            errors++;
            $display("%0t: distance expected %h actual %h", $time, want.distance,
                     out_signed_distance);
          end
          if (out_parallel_flag !== want.par) begin
            errors++;
            $display("%0t: parallel flag expected %b actual %b", $time, want.par,
                     out_parallel_flag);
          end
          if (out_degenerate_flag !== want.deg) begin
            errors++;
            $display("%0t: degenerate flag expected %b actual %b", $time, want.deg,
                     out_degenerate_flag);
          end
        end
      end
    end
  end
endmodule

// ----- tb/ray_plane_signed_distance_test.sv -----
// stimulus and verdict for the ray to plane signed distance block
`timescale 1ns / 1ps
module ray_plane_signed_distance_test;
  import rpsd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] fld [12];
  logic cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;
  logic out_strobe;
  logic signed [31:0] out_signed_distance;
  logic out_parallel_flag, out_degenerate_flag;
  int errors, pending;
  int cycles = 0;

  initial for (int i = 0; i < 12; i++) fld[i] = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ray_plane_signed_distance uut (
    .clk, .rst_n, .start, .busy,
    .in_ray_point_x(fld[0]), .in_ray_point_y(fld[1]), .in_ray_point_z(fld[2]),
    .in_ray_dir_x(fld[3]), .in_ray_dir_y(fld[4]), .in_ray_dir_z(fld[5]),
    .in_plane_point_x(fld[6]), .in_plane_point_y(fld[7]), .in_plane_point_z(fld[8]),
    .in_plane_normal_x(fld[9]), .in_plane_normal_y(fld[10]), .in_plane_normal_z(fld[11]),
    .cfg_we, .cfg_wdata,
    .out_strobe, .out_signed_distance, .out_parallel_flag, .out_degenerate_flag
  );

  ray_plane_signed_distance_check checker_i (
    .clk, .rst_n, .start, .busy,
    .in_ray_point_x(fld[0]), .in_ray_point_y(fld[1]), .in_ray_point_z(fld[2]),
    .in_ray_dir_x(fld[3]), .in_ray_dir_y(fld[4]), .in_ray_dir_z(fld[5]),
    .in_plane_point_x(fld[6]), .in_plane_point_y(fld[7]), .in_plane_point_z(fld[8]),
    .in_plane_normal_x(fld[9]), .in_plane_normal_y(fld[10]), .in_plane_normal_z(fld[11]),
    .cfg_we, .cfg_wdata,
    .out_strobe, .out_signed_distance, .out_parallel_flag, .out_degenerate_flag,
    .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("ray_plane_signed_distance_test: errors");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 4))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           3: return 32'hFFFF_FFFF;
           default: return 32'h1;
         endcase
      1, 2, 3, 4: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      default: return $urandom;
    endcase
  endfunction

  // hold start for one request until taken, then optionally idle
  task automatic send_request(input logic [31:0] v [12], input int gap);
    start <= 1'b1;
    for (int i = 0; i < 12; i++) fld[i] <= v[i];
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_set(input logic [31:0] a, b, c, d, e, f, g, h, i, j, k, l);
    logic [31:0] v [12];
    v = '{a, b, c, d, e, f, g, h, i, j, k, l};
    send_request(v, $urandom_range(0, 2));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  int gap;
  logic [31:0] v [12];
  logic [THR_W-1:0] phase_thr [5];

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset threshold
    send_set(0, 0, 0, 1 << 16, 0, 0, 0, 0, 0, 0, 0, 0);
    send_set(0, 0, 0, 1 << 16, 0, 0, 0, 0, 0, 0, 0, 1 << 16);
    send_set(0, 0, 0, 0, 0, 1 << 16, 0, 0, 1 << 16, 0, 0, 1 << 16);
    send_set(0, 0, 0, 0, 1 << 16, 0, 0, 1 << 16, 0, 0, 1 << 16, 0);
    send_set(0, 0, 0, 1 << 16, 0, 0, 1 << 16, 0, 0, 1 << 16, 0, 0);
    send_set(5 << 16, 3, 7, 1 << 16, 2 << 16, 3 << 16, 5 << 16, 3, 7, 0, 0, 1 << 16);
    send_set(0, 0, 0, 0, 0, 1 << 16, 0, 0, 3 << 16, 0, 0, 1 << 16);
    send_set(0, 0, 0, 0, 0, -(1 << 16), 0, 0, 3 << 16, 0, 0, 1 << 16);
    send_set(0, 0, 0, 0, 0, 1, 0, 0, 32'h7FFF_FFFF, 0, 0, 1);
    send_set(0, 0, 0, 0, 0, -1, 0, 0, 32'h7FFF_FFFF, 0, 0, 1);
    send_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_set(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_set(0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0, 1 << 16, -(1 << 16), 0);
    send_set(3 << 16, 0, 0, 1 << 12, 1 << 16, 0, 0, 0, 0, 1 << 16, 0, 0);
    send_set(3 << 16, 0, 0, 1 << 10, 1 << 16, 0, 0, 0, 0, 1 << 16, 0, 0);
    send_set(-(4 << 16), 2 << 16, 1 << 16, 1 << 16, -(1 << 16), 1 << 15,
             1 << 16, 0, -(1 << 16), 1 << 16, 1 << 16, 1 << 16);
    send_set(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1,
             1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    wait_drained();

    // zero threshold still flags orthogonal directions
    phase_thr = '{17'd0, 17'd65536, 17'h1FFFF, THR_RESET, 17'($urandom_range(1, 65535))};
    write_threshold(phase_thr[0]);
    send_set(0, 0, 0, 1 << 16, 0, 0, 0, 0, 0, 0, 0, 1 << 16);
    send_set(0, 0, 0, 1 << 12, 0, 1, 0, 0, 1 << 16, 0, 0, 1 << 16);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_threshold(phase_thr[ph]);
      end
      for (int n = 0; n < 326; n++) begin
        for (int i = 0; i < 12; i++) v[i] = pick_value();
        // zero some normal components so every axis choice is taken
        for (int i = 9; i < 12; i++) if ($urandom_range(0, 3) == 0) v[i] = '0;
        if ($urandom_range(0, 9) == 0) begin
          v[5] = '0;
          v[3] = v[10];
          v[4] = -v[9];
        end
        if ($urandom_range(0, 19) == 0) for (int i = 0; i < 3; i++) v[i] = v[6 + i];
        case ($urandom_range(0, 9))
          0: gap = $urandom_range(10, 60);
          1, 2, 3: gap = $urandom_range(1, 3);
          default: gap = 0;
        endcase
        send_request(v, gap);
        if (ph == 2 && n == 160) begin
          start <= 1'b0;
          do @(posedge clk); while (pending != 0);
        end
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ray_plane_signed_distance_test: clean");
    end else begin
      $display("ray_plane_signed_distance_test: errors");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/rpsd_pkg.sv
rtl/rpsd_mul.sv
rtl/rpsd_delay.sv
rtl/rpsd_front.sv
rtl/rpsd_root.sv
rtl/ray_plane_signed_distance.sv
tb/ray_plane_signed_distance_check.sv
tb/ray_plane_signed_distance_test.sv
